>>> sv/dlm_pkg.sv
// Shared constants, codes and controller/datapath handshake types for the deadlock matrix.
`timescale 1ns / 1ps

package dlm_pkg;

  // Default sizing of the matrix.
  localparam int DLM_MAX_PROCESSES = 8;
  localparam int DLM_MAX_RESOURCES = 4;
  localparam int DLM_COUNT_BITS    = 8;

  // Fixed field widths of the request and result words.
  localparam int KIND_W     = 2;
  localparam int PROCESS_W  = 3;
  localparam int RESOURCE_W = 2;
  localparam int AMOUNT_W   = 8;
  localparam int STUCK_W    = 3;
  localparam int FINISHED_W = 4;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam int PROC_CNT_W = 4;
  localparam int RES_CNT_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESOURCE_COUNT = 1'b1;

  localparam logic [PROC_CNT_W-1:0] PROC_CNT_RESET = 4'd8;
  localparam logic [RES_CNT_W-1:0]  RES_CNT_RESET  = 3'd4;

  typedef enum logic [KIND_W-1:0] {
    KIND_SET_FREE    = 2'd0,
    KIND_SET_REQUEST = 2'd1,
    KIND_GRANT       = 2'd2,
    KIND_DETECT      = 2'd3
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;     // capture the incoming request
    logic rd_item;   // read the rows of the request's process
    logic exec;      // apply a set or grant request
    logic det_init;  // start detection: load work from free counts
    logic rd_scan;   // read the rows of the process under scan
    logic eval;      // evaluate the process under scan
    logic next;      // advance to the next process
    logic restart;   // begin another pass
  } dlm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_e kind;
    logic  scan_last;
    logic  progress;
  } dlm_sts_t;

endpackage

>>> sv/dlm_ctrl.sv
// Sequencing state machine for the deadlock matrix.
`timescale 1ns / 1ps

module dlm_ctrl
  import dlm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     out_free_i,
  output logic     load_out_o,
  input  dlm_sts_t sts_i,
  output dlm_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_READ    = 6'b000010,
    S_EXEC    = 6'b000100,
    S_SCAN_RD = 6'b001000,
    S_SCAN_EV = 6'b010000,
    S_DONE    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    load_out_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_READ;
        end
      end
      S_READ: begin
        if (sts_i.kind == KIND_DETECT) begin
          cmd_o.det_init = 1'b1;
          state_d        = S_SCAN_RD;
        end else begin
          cmd_o.rd_item = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_DONE;
      end
      S_SCAN_RD: begin
        cmd_o.rd_scan = 1'b1;
        state_d       = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        cmd_o.eval = 1'b1;
        if (sts_i.scan_last) begin
          // A pass that finished nobody ends the search.
          if (sts_i.progress) begin
            cmd_o.restart = 1'b1;
            state_d       = S_SCAN_RD;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          cmd_o.next = 1'b1;
          state_d    = S_SCAN_RD;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          load_out_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/dlm_datapath.sv
// Count storage, grant arithmetic and the work/finish scan of the deadlock matrix.
`timescale 1ns / 1ps

module dlm_datapath
  import dlm_pkg::*;
#(
  parameter int MAX_PROCESSES = DLM_MAX_PROCESSES,
  parameter int MAX_RESOURCES = DLM_MAX_RESOURCES,
  parameter int COUNT_BITS    = DLM_COUNT_BITS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  dlm_cmd_t                               cmd_i,
  output dlm_sts_t                               sts_o,
  input  logic [IN_TDATA_W-1:0]                  item_i,
  input  logic [$clog2(MAX_PROCESSES+1)-1:0]     np_i,
  input  logic [$clog2(MAX_RESOURCES+1)-1:0]     nr_i,
  output logic                                   res_deadlock_o,
  output logic [STUCK_W-1:0]                     res_stuck_o,
  output logic                                   res_status_o,
  output logic [FINISHED_W-1:0]                  res_finished_o
);

  localparam int PAW = $clog2(MAX_PROCESSES);
  localparam int RIW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int NPW = $clog2(MAX_PROCESSES + 1);
  localparam int NRW = $clog2(MAX_RESOURCES + 1);
  localparam int CB  = COUNT_BITS;
  localparam int WW  = COUNT_BITS + NPW;
  localparam int AXW = (AMOUNT_W > CB) ? AMOUNT_W : CB;
  localparam int PXW = (PROCESS_W > PAW) ? PROCESS_W : PAW;
  localparam int RXW = (RESOURCE_W > RIW) ? RESOURCE_W : RIW;
  localparam int PCW = (PROCESS_W > NPW) ? PROCESS_W : NPW;
  localparam int RCW = (RESOURCE_W > NRW) ? RESOURCE_W : NRW;
  localparam int SXW = (PAW > STUCK_W) ? PAW : STUCK_W;
  localparam int FXW = (NPW > FINISHED_W) ? NPW : FINISHED_W;

  // Captured request.
  kind_e                 kind_q;
  logic [PROCESS_W-1:0]  proc_q;
  logic [RESOURCE_W-1:0] res_q;
  logic [CB-1:0]         amt_q;

  // Row storage: one row per process, one lane per resource.
  logic [MAX_RESOURCES-1:0][CB-1:0] held_mem [MAX_PROCESSES];
  logic [MAX_RESOURCES-1:0][CB-1:0] pend_mem [MAX_PROCESSES];
  logic [MAX_PROCESSES-1:0]         held_vld_q, pend_vld_q;
  logic [MAX_RESOURCES-1:0][CB-1:0] held_rd_q, pend_rd_q;
  logic                             held_rv_q, pend_rv_q;
  logic [MAX_RESOURCES-1:0][CB-1:0] held_row, pend_row;

  logic [CB-1:0] free_q [MAX_RESOURCES];

  // Detection state.
  logic [WW-1:0]            work_q [MAX_RESOURCES];
  logic [MAX_PROCESSES-1:0] fin_q;
  logic [NPW-1:0]           fin_cnt_q;
  logic [PAW-1:0]           idx_q;
  logic                     prog_q;
  logic                     first_q;
  logic [PAW-1:0]           stuck_q;
  logic                     status_q;

  logic [AXW-1:0] amt_ext;
  logic [PXW-1:0] proc_ext;
  logic [RXW-1:0] res_ext;
  logic [PAW-1:0] p_addr;
  logic [RIW-1:0] r_lane;
  logic           p_ok, r_ok;
  logic [PAW-1:0] rd_addr;
  logic           rd_en;

  logic [MAX_RESOURCES-1:0][CB-1:0] held_new, pend_clr, pend_set, pend_wdata;
  logic [CB-1:0]                    free_new [MAX_RESOURCES];
  logic [MAX_RESOURCES-1:0]         under;
  logic                             held_we, pend_we;
  logic                             fits, fit_now, unfinished;
  logic [SXW-1:0]                   stuck_ext;
  logic [FXW-1:0]                   fin_ext;

  assign amt_ext  = AXW'(item_i[14:7]);
  assign proc_ext = PXW'(proc_q);
  assign res_ext  = RXW'(res_q);
  assign p_addr   = proc_ext[PAW-1:0];
  assign r_lane   = res_ext[RIW-1:0];
  assign p_ok     = PCW'(proc_q) < PCW'(np_i);
  assign r_ok     = RCW'(res_q) < RCW'(nr_i);

  assign rd_addr = cmd_i.rd_scan ? idx_q : p_addr;
  assign rd_en   = cmd_i.rd_scan | cmd_i.rd_item;

  // A row never written reads as all zero.
  assign held_row = held_rv_q ? held_rd_q : '0;
  assign pend_row = pend_rv_q ? pend_rd_q : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q <= kind_e'(item_i[1:0]);
      proc_q <= item_i[4:2];
      res_q  <= item_i[6:5];
      amt_q  <= amt_ext[CB-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      held_rd_q <= held_mem[rd_addr];
      pend_rd_q <= pend_mem[rd_addr];
    end
    if (held_we) begin
      held_mem[p_addr] <= held_new;
    end
    if (pend_we) begin
      pend_mem[p_addr] <= pend_wdata;
    end
  end

  // Per-lane grant and set arithmetic; lanes beyond the active count are left alone.
  always_comb begin
    logic [CB:0] sum;
    logic        lane_on;
    sum = '0;
    for (int j = 0; j < MAX_RESOURCES; j++) begin
      lane_on     = NRW'(j) < nr_i;
      sum         = {1'b0, held_row[j]} + {1'b0, pend_row[j]};
      held_new[j] = lane_on ? (sum[CB] ? {CB{1'b1}} : sum[CB-1:0]) : held_row[j];
      under[j]    = lane_on && (pend_row[j] > free_q[j]);
      if (!lane_on) begin
        free_new[j] = free_q[j];
      end else if (under[j]) begin
        free_new[j] = '0;
      end else begin
        free_new[j] = free_q[j] - pend_row[j];
      end
      pend_clr[j] = lane_on ? '0 : pend_row[j];
      pend_set[j] = (RIW'(j) == r_lane) ? amt_q : pend_row[j];
    end
  end

  assign held_we    = cmd_i.exec && (kind_q == KIND_GRANT) && p_ok;
  assign pend_we    = cmd_i.exec && (((kind_q == KIND_SET_REQUEST) && p_ok && r_ok) ||
                                     ((kind_q == KIND_GRANT) && p_ok));
  assign pend_wdata = (kind_q == KIND_GRANT) ? pend_clr : pend_set;

  // A process fits when every active request is covered by the work totals.
  always_comb begin
    fits = 1'b1;
    for (int j = 0; j < MAX_RESOURCES; j++) begin
      if ((NRW'(j) < nr_i) && (WW'(pend_row[j]) > work_q[j])) begin
        fits = 1'b0;
      end
    end
  end

  assign fit_now    = !fin_q[idx_q] && fits;
  assign unfinished = !fin_q[idx_q] && !fits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_vld_q <= '0;
      pend_vld_q <= '0;
      held_rv_q  <= 1'b0;
      pend_rv_q  <= 1'b0;
      for (int j = 0; j < MAX_RESOURCES; j++) begin
        free_q[j] <= '0;
        work_q[j] <= '0;
      end
      fin_q     <= '0;
      fin_cnt_q <= '0;
      idx_q     <= '0;
      prog_q    <= 1'b0;
      first_q   <= 1'b0;
      stuck_q   <= '0;
      status_q  <= 1'b0;
    end else begin
      if (rd_en) begin
        held_rv_q <= held_vld_q[rd_addr];
        pend_rv_q <= pend_vld_q[rd_addr];
      end
      if (held_we) begin
        held_vld_q[p_addr] <= 1'b1;
      end
      if (pend_we) begin
        pend_vld_q[p_addr] <= 1'b1;
      end
      if (cmd_i.latch) begin
        status_q <= 1'b0;
      end
      if (cmd_i.exec) begin
        case (kind_q)
          KIND_SET_FREE: begin
            if (r_ok) begin
              free_q[r_lane] <= amt_q;
            end
          end
          KIND_GRANT: begin
            if (p_ok) begin
              for (int j = 0; j < MAX_RESOURCES; j++) begin
                free_q[j] <= free_new[j];
              end
              status_q <= |under;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.det_init) begin
        for (int j = 0; j < MAX_RESOURCES; j++) begin
          work_q[j] <= WW'(free_q[j]);
        end
        fin_q     <= '0;
        fin_cnt_q <= '0;
        idx_q     <= '0;
        prog_q    <= 1'b0;
        first_q   <= 1'b0;
        stuck_q   <= '0;
      end
      if (cmd_i.eval) begin
        if (fit_now) begin
          fin_q[idx_q] <= 1'b1;
          fin_cnt_q    <= fin_cnt_q + 1'b1;
          for (int j = 0; j < MAX_RESOURCES; j++) begin
            if (NRW'(j) < nr_i) begin
              work_q[j] <= work_q[j] + WW'(held_row[j]);
            end
          end
        end
        if (cmd_i.restart) begin
          // A new pass starts with no progress and no unfinished process seen yet.
          prog_q  <= 1'b0;
          first_q <= 1'b0;
          stuck_q <= '0;
        end else begin
          if (fit_now) begin
            prog_q <= 1'b1;
          end
          // The last pass changes nothing, so its first unfinished process is the answer.
          if (unfinished && !first_q) begin
            first_q <= 1'b1;
            stuck_q <= idx_q;
          end
        end
      end
      if (cmd_i.next) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.restart) begin
        idx_q <= '0;
      end
    end
  end

  assign sts_o.kind      = kind_q;
  assign sts_o.scan_last = NPW'(idx_q) == (np_i - 1'b1);
  assign sts_o.progress  = prog_q | fit_now;

  assign stuck_ext = SXW'(stuck_q);
  assign fin_ext   = FXW'(fin_cnt_q);

  always_comb begin
    if (kind_q == KIND_DETECT) begin
      res_deadlock_o = first_q;
      res_stuck_o    = stuck_ext[STUCK_W-1:0];
      res_status_o   = 1'b0;
      res_finished_o = fin_ext[FINISHED_W-1:0];
    end else begin
      res_deadlock_o = 1'b0;
      res_stuck_o    = '0;
      res_status_o   = status_q;
      res_finished_o = '0;
    end
  end

endmodule

>>> sv/deadlock_detection_matrix.sv
// Set and grant requests: the request is latched, its process rows read, it is applied
// and the result loaded into the output register. Detection scans in passes, np the
// active process count, passes at most np + 1; each process needs a row read and an
// evaluation step in the scan loop. One request is in work at a time; the next is
// accepted while a result waits in the output register. Reset clears counts, configuration
// (8 processes, 4 resources) and control state at once; no clearing pass is needed.
`timescale 1ns / 1ps

module deadlock_detection_matrix
  import dlm_pkg::*;
#(
  parameter int MAX_PROCESSES = DLM_MAX_PROCESSES,
  parameter int MAX_RESOURCES = DLM_MAX_RESOURCES,
  parameter int COUNT_BITS    = DLM_COUNT_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // kind[1:0], process[4:2], resource[6:5], amount[14:7], zero fill above
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // deadlock[0], stuck_process[3:1], status[4], finished_count[8:5], zero fill above
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int NPW = $clog2(MAX_PROCESSES + 1);
  localparam int NRW = $clog2(MAX_RESOURCES + 1);
  localparam int PKW = (PROC_CNT_W > NPW) ? PROC_CNT_W : NPW;
  localparam int RKW = (RES_CNT_W > NRW) ? RES_CNT_W : NRW;

  logic [PROC_CNT_W-1:0] proc_cnt_q;
  logic [RES_CNT_W-1:0]  res_cnt_q;
  logic [PKW-1:0]        pc_ext, np_full;
  logic [RKW-1:0]        rc_ext, nr_full;
  logic [NPW-1:0]        np;
  logic [NRW-1:0]        nr;

  dlm_cmd_t cmd;
  dlm_sts_t sts;
  logic     load_out;
  logic     out_free;

  logic                  res_deadlock, res_status;
  logic [STUCK_W-1:0]    res_stuck;
  logic [FINISHED_W-1:0] res_finished;

  logic                   out_vld_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proc_cnt_q <= PROC_CNT_RESET;
      res_cnt_q  <= RES_CNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PROCESS_COUNT:  proc_cnt_q <= cfg_data_i;
        CFG_RESOURCE_COUNT: res_cnt_q  <= cfg_data_i[RES_CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Counts of zero act as one; counts above the maximum act as the maximum.
  assign pc_ext = PKW'(proc_cnt_q);
  assign rc_ext = RKW'(res_cnt_q);

  always_comb begin
    if (pc_ext == '0) begin
      np_full = PKW'(1);
    end else if (pc_ext > PKW'(MAX_PROCESSES)) begin
      np_full = PKW'(MAX_PROCESSES);
    end else begin
      np_full = pc_ext;
    end
    if (rc_ext == '0) begin
      nr_full = RKW'(1);
    end else if (rc_ext > RKW'(MAX_RESOURCES)) begin
      nr_full = RKW'(MAX_RESOURCES);
    end else begin
      nr_full = rc_ext;
    end
  end

  assign np = np_full[NPW-1:0];
  assign nr = nr_full[NRW-1:0];

  assign out_free = !out_vld_q || m_axis_tready;

  dlm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .load_out_o (load_out),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dlm_datapath #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .MAX_RESOURCES (MAX_RESOURCES),
    .COUNT_BITS    (COUNT_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .item_i         (s_axis_tdata),
    .np_i           (np),
    .nr_i           (nr),
    .res_deadlock_o (res_deadlock),
    .res_stuck_o    (res_stuck),
    .res_status_o   (res_status),
    .res_finished_o (res_finished)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load_out) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= OUT_TDATA_W'({res_finished, res_status, res_stuck, res_deadlock});
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> test/testbench.sv
// Self-checking testbench for the deadlock detection matrix, stream in and out.
`timescale 1ns / 1ps

module testbench;
  import dlm_pkg::*;

  localparam int COUNT_MAX = (1 << DLM_COUNT_BITS) - 1;

  // One input item, packed to match s_axis_tdata from bit 0 up.
  typedef struct packed {
    logic [AMOUNT_W-1:0]   amount;
    logic [RESOURCE_W-1:0] res_idx;
    logic [PROCESS_W-1:0]  proc_idx;
    kind_e                 kind;
  } matrix_req_t;

  // One result, packed to match m_axis_tdata from bit 0 up.
  typedef struct packed {
    logic [FINISHED_W-1:0] finished_count;
    logic                  status;
    logic [STUCK_W-1:0]    stuck_process;
    logic                  deadlock;
  } verdict_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // kind[1:0], process[4:2], resource[6:5], amount[14:7], zero fill above
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // deadlock[0], stuck_process[3:1], status[4], finished_count[8:5], zero fill above
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  deadlock_detection_matrix u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the matrix state and configuration.
  int held_cnt  [DLM_MAX_PROCESSES][DLM_MAX_RESOURCES];
  int want_cnt  [DLM_MAX_PROCESSES][DLM_MAX_RESOURCES];
  int avail_cnt [DLM_MAX_RESOURCES];
  logic [PROC_CNT_W-1:0] proc_cfg = PROC_CNT_RESET;
  logic [RES_CNT_W-1:0]  res_cfg  = RES_CNT_RESET;

  matrix_req_t queued_requests[$];
  verdict_t    expected_verdicts[$];
  int          requests_queued = 0;
  int          fail_count = 0;

  logic [3:0] proc_plan [7] = '{4'd0, 4'd1, 4'd15, 4'd3, 4'd8, 4'd5, 4'd9};
  logic [3:0] res_plan  [7] = '{4'd0, 4'd1, 4'd7, 4'd2, 4'd4, 4'd3, 4'd5};

  function automatic int eff_procs();
    if (proc_cfg == 0) return 1;
    if (proc_cfg > DLM_MAX_PROCESSES) return DLM_MAX_PROCESSES;
    return proc_cfg;
  endfunction

  function automatic int eff_res();
    if (res_cfg == 0) return 1;
    if (res_cfg > DLM_MAX_RESOURCES) return DLM_MAX_RESOURCES;
    return res_cfg;
  endfunction

  // Applies one request to the shadow state and returns the verdict it must produce.
  function automatic verdict_t apply_request(matrix_req_t rq);
    verdict_t v;
    int       np, nr, sum, nfin;
    int       work [DLM_MAX_RESOURCES];
    bit       done [DLM_MAX_PROCESSES];
    bit       progress, fits, found;
    v  = '0;
    np = eff_procs();
    nr = eff_res();
    case (rq.kind)
      KIND_SET_FREE: begin
        if (rq.res_idx < nr) avail_cnt[rq.res_idx] = rq.amount;
      end
      KIND_SET_REQUEST: begin
        if (rq.proc_idx < np && rq.res_idx < nr) want_cnt[rq.proc_idx][rq.res_idx] = rq.amount;
      end
      KIND_GRANT: begin
        if (rq.proc_idx < np) begin
          for (int j = 0; j < nr; j++) begin
            sum = held_cnt[rq.proc_idx][j] + want_cnt[rq.proc_idx][j];
            held_cnt[rq.proc_idx][j] = (sum > COUNT_MAX) ? COUNT_MAX : sum;
            if (want_cnt[rq.proc_idx][j] > avail_cnt[j]) begin
              avail_cnt[j] = 0;
              v.status = 1'b1;
            end else begin
              avail_cnt[j] -= want_cnt[rq.proc_idx][j];
            end
            want_cnt[rq.proc_idx][j] = 0;
          end
        end
      end
      default: begin
        nfin = 0;
        for (int i = 0; i < DLM_MAX_PROCESSES; i++) done[i] = 1'b0;
        for (int j = 0; j < DLM_MAX_RESOURCES; j++) work[j] = avail_cnt[j];
        progress = 1'b1;
        // Keep sweeping until a whole pass releases nothing new.
        while (progress) begin
          progress = 1'b0;
          for (int i = 0; i < np; i++) begin
            if (!done[i]) begin
              fits = 1'b1;
              for (int j = 0; j < nr; j++) if (want_cnt[i][j] > work[j]) fits = 1'b0;
              if (fits) begin
                done[i]  = 1'b1;
                progress = 1'b1;
                nfin++;
                for (int j = 0; j < nr; j++) work[j] += held_cnt[i][j];
              end
            end
          end
        end
        found = 1'b0;
        for (int i = 0; i < np; i++) begin
          if (!done[i] && !found) begin
            found           = 1'b1;
            v.deadlock      = 1'b1;
            v.stuck_process = i[STUCK_W-1:0];
          end
        end
        v.finished_count = nfin[FINISHED_W-1:0];
      end
    endcase
    return v;
  endfunction

  task automatic push_item(kind_e k, int p, int r, int a);
    matrix_req_t rq;
    rq.kind     = k;
    rq.proc_idx = p[PROCESS_W-1:0];
    rq.res_idx  = r[RESOURCE_W-1:0];
    rq.amount   = a[AMOUNT_W-1:0];
    queued_requests.push_back(rq);
    requests_queued++;
  endtask

  // Mostly an index in use, now and then any index the field allows.
  function automatic int pick_index(int count, int field_max);
    if ($urandom_range(0, 6) == 0) return $urandom_range(0, field_max);
    return $urandom_range(0, count - 1);
  endfunction

  function automatic int pick_amount();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 12);
    return $urandom_range(0, COUNT_MAX);
  endfunction

  // Set some free counts, post requests, grant a few processes, then run detection.
  task automatic push_scenario();
    int np, nr;
    np = eff_procs();
    nr = eff_res();
    repeat ($urandom_range(0, nr))
      push_item(KIND_SET_FREE, $urandom_range(0, 7), pick_index(nr, 3), pick_amount());
    repeat ($urandom_range(1, 2 * np))
      push_item(KIND_SET_REQUEST, pick_index(np, 7), pick_index(nr, 3), pick_amount());
    repeat ($urandom_range(0, 3))
      push_item(KIND_GRANT, pick_index(np, 7), $urandom_range(0, 3), $urandom_range(0, 255));
    repeat ($urandom_range(0, np))
      push_item(KIND_SET_REQUEST, pick_index(np, 7), pick_index(nr, 3), pick_amount());
    push_item(KIND_DETECT, $urandom_range(0, 7), $urandom_range(0, 3), $urandom_range(0, 255));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [3:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    if (idx == CFG_PROCESS_COUNT) proc_cfg = value[PROC_CNT_W-1:0];
    else res_cfg = value[RES_CNT_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (queued_requests.size() != 0 || expected_verdicts.size() != 0 || s_axis_tvalid)
      @(negedge clk_i);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  matrix_req_t offered_req;
  int          burst_left = 0;
  int          gap_left = 0;

  always @(posedge clk_i) begin : driver
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) expected_verdicts.push_back(apply_request(offered_req));
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (queued_requests.size() != 0) begin
          offered_req = queued_requests.pop_front();
          s_axis_tdata  <= {1'b0, offered_req};
          s_axis_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 20);
            gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern switches between none, light and heavy, plus one long hold-off
  // that lets the block fill up and push back on its input.
  int results_taken = 0;
  int stall_mode = 0;
  int stall_timer = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk_i) begin : receiver
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) results_taken++;
      if (stall_timer == 0) begin
        stall_mode  = $urandom_range(0, 2);
        stall_timer = $urandom_range(20, 80);
      end else begin
        stall_timer--;
      end
      if (!hold_done && results_taken == 150) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    verdict_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(verdict_t)-1:0];
      if (expected_verdicts.size() == 0) begin
        $error("result 0x%h arrived with no request outstanding", m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_verdicts.pop_front();
        check_field("deadlock", want.deadlock, got.deadlock);
        check_field("stuck_process", want.stuck_process, got.stuck_process);
        check_field("status", want.status, got.status);
        check_field("finished_count", want.finished_count, got.finished_count);
      end
    end
  end

  initial begin
    int phase_start;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Extremes, saturation, clamped grants and a release that needs a second pass.
    push_item(KIND_SET_FREE, 0, 0, 255);
    push_item(KIND_SET_FREE, 7, 1, 0);
    push_item(KIND_SET_FREE, 0, 2, 170);
    push_item(KIND_SET_FREE, 0, 3, 85);
    push_item(KIND_SET_REQUEST, 0, 0, 200);
    push_item(KIND_SET_REQUEST, 7, 3, 255);
    push_item(KIND_DETECT, 0, 0, 0);
    push_item(KIND_GRANT, 0, 0, 0);
    push_item(KIND_SET_REQUEST, 0, 0, 200);
    push_item(KIND_GRANT, 0, 3, 255);
    push_item(KIND_GRANT, 7, 0, 0);
    push_item(KIND_SET_REQUEST, 3, 1, 1);
    push_item(KIND_DETECT, 7, 3, 255);
    push_item(KIND_SET_FREE, 0, 1, 1);
    push_item(KIND_DETECT, 0, 0, 0);
    push_item(KIND_SET_REQUEST, 6, 2, 100);
    push_item(KIND_GRANT, 6, 0, 0);
    push_item(KIND_SET_REQUEST, 1, 2, 160);
    push_item(KIND_DETECT, 0, 0, 0);
    push_item(KIND_SET_REQUEST, 5, 0, 100);
    push_item(KIND_GRANT, 5, 0, 0);
    push_item(KIND_DETECT, 0, 0, 0);
    wait_idle();

    for (int ph = 0; ph < 7; ph++) begin
      write_reg(CFG_PROCESS_COUNT, proc_plan[ph]);
      write_reg(CFG_RESOURCE_COUNT, res_plan[ph]);
      @(negedge clk_i);
      if (ph == 0) begin
        // Both counts read as one here, so these indexes are out of range.
        push_item(KIND_SET_FREE, 0, 1, 9);
        push_item(KIND_SET_REQUEST, 1, 0, 9);
        push_item(KIND_SET_REQUEST, 0, 3, 9);
        push_item(KIND_GRANT, 4, 0, 0);
        push_item(KIND_DETECT, 7, 3, 255);
      end
      phase_start = requests_queued;
      while (requests_queued - phase_start < 75) begin
        if ($urandom_range(0, 9) < 8) push_scenario();
        else push_item(kind_e'($urandom_range(0, 3)), $urandom_range(0, 7),
                       $urandom_range(0, 3), $urandom_range(0, 255));
      end
      wait_idle();
    end

    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && expected_verdicts.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

>>> filelist.f
sv/dlm_pkg.sv
sv/dlm_ctrl.sv
sv/dlm_datapath.sv
sv/deadlock_detection_matrix.sv
test/testbench.sv
